### design/cbf_pkg.sv
`timescale 1ns / 1ps

package cbf_pkg;

    localparam int CHUNK_SIZE_DEF = 16;

    localparam int NUM_REGS   = 8;
    localparam int REG_W      = 64;
    localparam int IDX_W      = 3;
    localparam int COORD_IN_W = 16;
    localparam int ENTRY_W    = 32;
    localparam int NUM_ROWS   = 4;
    localparam int NUM_COLS   = 4;
    localparam int NUM_CORNERS = 8;

    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef logic [REG_W-1:0] cfg_word_t;
    typedef logic [IDX_W-1:0] cfg_idx_t;

    // Capture enables, one per pipeline stage after the input register
    typedef struct packed {
        logic prod;
        logic pair;
        logic sum;
        logic out;
    } pipe_en_t;

endpackage

### design/cbf_chunk_if.sv
`timescale 1ns / 1ps

interface cbf_chunk_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [cbf_pkg::COORD_IN_W-1:0]   chunk_x;
    logic signed [cbf_pkg::COORD_IN_W-1:0]   chunk_y;
    logic signed [cbf_pkg::COORD_IN_W-1:0]   chunk_z;

    modport source (output valid, output chunk_x, output chunk_y, output chunk_z,
                    input ready);
    modport sink   (input valid, input chunk_x, input chunk_y, input chunk_z,
                    output ready);
endinterface

### design/cbf_vis_if.sv
`timescale 1ns / 1ps

interface cbf_vis_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, output visible, input ready);
    modport sink   (input valid, input visible, output ready);
endinterface

### design/chunk_box_frustum_corner_test_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                     Handshake
// chunk     in   chunk_x, chunk_y, chunk_z   valid / ready
// result    out  visible                     valid / ready
// cfg       in   cfg_index, cfg_data         cfg_we, no back-pressure
//
// One chunk per cycle sustained while result.ready stays high; each chunk passes
// the coordinate register (loaded on the accepting edge), then product register,
// pair-sum, corner-sum and compare stages.
// Each stage holds only while the stage after it is full and stalled, so
// bubbles collapse and chunk.ready drops only when all five stages are full.
// Reset clears the matrix to zero and empties the pipeline; no clearing pass.

module chunk_box_frustum_corner_test_core
#(
    parameter int CHUNK_SIZE = cbf_pkg::CHUNK_SIZE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  cbf_pkg::cfg_idx_t   cfg_index,
    input  cbf_pkg::cfg_word_t  cfg_data,
    cbf_chunk_if.sink           chunk,
    cbf_vis_if.source           result
);

    // Corner coordinate width: chunk + 1 scaled by CHUNK_SIZE, signed
    localparam int CW = cbf_pkg::COORD_IN_W + 1 + $clog2(CHUNK_SIZE + 1);
    localparam int SW = cbf_pkg::ENTRY_W + CW + 2;

    cbf_pkg::entry_t    m_ent [cbf_pkg::NUM_ROWS][cbf_pkg::NUM_COLS];
    cbf_pkg::pipe_en_t  pen;

    logic               v_in_reg;
    logic               v_prod_reg;
    logic               v_pair_reg;
    logic               v_sum_reg;
    logic               v_out_reg;
    logic               en_in;

    logic signed [CW-1:0] cx_reg [2];
    logic signed [CW-1:0] cy_reg [2];
    logic signed [CW-1:0] cz_reg [2];
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;

    logic signed [SW-1:0] clip [cbf_pkg::NUM_ROWS][cbf_pkg::NUM_CORNERS];

    cbf_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ent     (m_ent)
    );

    // Stage enables: a stage captures when empty or when its successor moves
    assign pen.out  = !v_out_reg  || result.ready;
    assign pen.sum  = !v_sum_reg  || pen.out;
    assign pen.pair = !v_pair_reg || pen.sum;
    assign pen.prod = !v_prod_reg || pen.pair;
    assign en_in    = !v_in_reg   || pen.prod;
    assign chunk.ready = en_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg   <= 1'b0;
            v_prod_reg <= 1'b0;
            v_pair_reg <= 1'b0;
            v_sum_reg  <= 1'b0;
            v_out_reg  <= 1'b0;
        end
        else
        begin
            if (en_in)
            begin
                v_in_reg <= chunk.valid;
            end
            if (pen.prod)
            begin
                v_prod_reg <= v_in_reg;
            end
            if (pen.pair)
            begin
                v_pair_reg <= v_prod_reg;
            end
            if (pen.sum)
            begin
                v_sum_reg <= v_pair_reg;
            end
            if (pen.out)
            begin
                v_out_reg <= v_sum_reg;
            end
        end
    end

    assign bx = CW'(chunk.chunk_x);
    assign by = CW'(chunk.chunk_y);
    assign bz = CW'(chunk.chunk_z);

    // Low and high face of the box along each axis
    always_ff @(posedge clk)
    begin
        if (en_in)
        begin
            cx_reg[0] <= bx * CW'(CHUNK_SIZE);
            cx_reg[1] <= (bx + CW'(1)) * CW'(CHUNK_SIZE);
            cy_reg[0] <= by * CW'(CHUNK_SIZE);
            cy_reg[1] <= (by + CW'(1)) * CW'(CHUNK_SIZE);
            cz_reg[0] <= bz * CW'(CHUNK_SIZE);
            cz_reg[1] <= (bz + CW'(1)) * CW'(CHUNK_SIZE);
        end
    end

    for (genvar r = 0; r < cbf_pkg::NUM_ROWS; r++)
    begin : g_row
        cbf_row_eval
        #(
            .CW (CW),
            .SW (SW)
        )
        u_row_eval
        (
            .clk      (clk),
            .pen      (pen),
            .m_ent    (m_ent[r]),
            .cx       (cx_reg),
            .cy       (cy_reg),
            .cz       (cz_reg),
            .clip_sum (clip[r])
        );
    end

    cbf_inside_test
    #(
        .SW (SW)
    )
    u_inside_test
    (
        .clk     (clk),
        .pen     (pen),
        .clip    (clip),
        .visible (result.visible)
    );

    assign result.valid = v_out_reg;

    a_prod_adv: assert property (@(posedge clk) disable iff (!rst_n)
        v_prod_reg && pen.pair |=> v_pair_reg)
        else $error("product stage transaction lost");

    a_out_adv: assert property (@(posedge clk) disable iff (!rst_n)
        v_sum_reg && pen.out |=> result.valid)
        else $error("corner sum did not reach the result register");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pen.prod |-> v_prod_reg && v_pair_reg && v_sum_reg && v_out_reg && !result.ready)
        else $error("product stage held while pipeline has a bubble");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !chunk.ready |-> v_in_reg && !pen.prod)
        else $error("input refused with room in the pipeline");

endmodule

### design/cbf_cfg_regs.sv
`timescale 1ns / 1ps

module cbf_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  cbf_pkg::cfg_idx_t   cfg_index,
    input  cbf_pkg::cfg_word_t  cfg_data,
    output cbf_pkg::entry_t     m_ent [cbf_pkg::NUM_ROWS][cbf_pkg::NUM_COLS]
);

    cbf_pkg::cfg_word_t regs_reg [cbf_pkg::NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cbf_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    // Two entries per register: lower column in the low half
    for (genvar r = 0; r < cbf_pkg::NUM_ROWS; r++)
    begin : g_row
        assign m_ent[r][0] = regs_reg[2*r][cbf_pkg::ENTRY_W-1:0];
        assign m_ent[r][1] = regs_reg[2*r][cbf_pkg::REG_W-1:cbf_pkg::ENTRY_W];
        assign m_ent[r][2] = regs_reg[2*r+1][cbf_pkg::ENTRY_W-1:0];
        assign m_ent[r][3] = regs_reg[2*r+1][cbf_pkg::REG_W-1:cbf_pkg::ENTRY_W];
    end

endmodule

### design/cbf_row_eval.sv
`timescale 1ns / 1ps

module cbf_row_eval
#(
    parameter int CW = 22,
    parameter int SW = cbf_pkg::ENTRY_W + CW + 2
)
(
    input  logic                  clk,
    input  cbf_pkg::pipe_en_t     pen,
    input  cbf_pkg::entry_t       m_ent [cbf_pkg::NUM_COLS],
    input  logic signed [CW-1:0]  cx [2],
    input  logic signed [CW-1:0]  cy [2],
    input  logic signed [CW-1:0]  cz [2],
    output logic signed [SW-1:0]  clip_sum [cbf_pkg::NUM_CORNERS]
);

    localparam int PW = cbf_pkg::ENTRY_W + CW;

    logic signed [PW-1:0] px_reg [2];
    logic signed [PW-1:0] py_reg [2];
    logic signed [PW-1:0] pz_reg [2];
    logic signed [SW-1:0] sxy_reg [4];
    logic signed [SW-1:0] szc_reg [2];
    logic signed [SW-1:0] sum_reg [cbf_pkg::NUM_CORNERS];

    // Each axis contributes at its low or high face only, so the eight
    // corners share six products per row.
    always_ff @(posedge clk)
    begin
        if (pen.prod)
        begin
            for (int i = 0; i < 2; i++)
            begin
                px_reg[i] <= PW'(m_ent[0]) * PW'(cx[i]);
                py_reg[i] <= PW'(m_ent[1]) * PW'(cy[i]);
                pz_reg[i] <= PW'(m_ent[2]) * PW'(cz[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pen.pair)
        begin
            for (int iy = 0; iy < 2; iy++)
            begin
                for (int ix = 0; ix < 2; ix++)
                begin
                    sxy_reg[iy*2+ix] <= SW'(px_reg[ix]) + SW'(py_reg[iy]);
                end
            end
            for (int iz = 0; iz < 2; iz++)
            begin
                szc_reg[iz] <= SW'(pz_reg[iz]) + SW'(m_ent[3]);
            end
        end
    end

    // Corner k: x face from bit 0, z face from bit 1, y face from bit 2
    always_ff @(posedge clk)
    begin
        if (pen.sum)
        begin
            for (int k = 0; k < cbf_pkg::NUM_CORNERS; k++)
            begin
                sum_reg[k] <= sxy_reg[((k >> 2) & 1) * 2 + (k & 1)]
                            + szc_reg[(k >> 1) & 1];
            end
        end
    end

    assign clip_sum = sum_reg;

endmodule

### design/cbf_inside_test.sv
`timescale 1ns / 1ps

module cbf_inside_test
#(
    parameter int SW = 56
)
(
    input  logic                  clk,
    input  cbf_pkg::pipe_en_t     pen,
    input  logic signed [SW-1:0]  clip [cbf_pkg::NUM_ROWS][cbf_pkg::NUM_CORNERS],
    output logic                  visible
);

    logic                         visible_reg;
    logic                         visible_next;
    logic [cbf_pkg::NUM_CORNERS-1:0] corner_in;
    logic signed [SW-1:0]         neg_w [cbf_pkg::NUM_CORNERS];

    always_comb
    begin
        for (int k = 0; k < cbf_pkg::NUM_CORNERS; k++)
        begin
            neg_w[k]     = -clip[3][k];
            corner_in[k] = (clip[0][k] > neg_w[k]) && (clip[0][k] < clip[3][k])
                        && (clip[1][k] > neg_w[k]) && (clip[1][k] < clip[3][k])
                        && (clip[2][k] > neg_w[k]) && (clip[2][k] < clip[3][k]);
        end
        visible_next = |corner_in;
    end

    always_ff @(posedge clk)
    begin
        if (pen.out)
        begin
            visible_reg <= visible_next;
        end
    end

    assign visible = visible_reg;

endmodule

### sim/chunk_box_frustum_corner_test_core_tb.sv
`timescale 1ns / 1ps

module chunk_box_frustum_corner_test_core_tb;

    import cbf_pkg::*;

    localparam int     CHUNK       = CHUNK_SIZE_DEF;
    localparam longint CHUNK_L     = CHUNK;
    localparam int     PIPE_DEPTH  = 5;
    localparam int     SEG_ITEMS   = 78;
    localparam int     SEGS        = 5;
    localparam int     NUM_DIR     = 21;

    localparam cfg_idx_t REG_X01 = 3'd0;
    localparam cfg_idx_t REG_X23 = 3'd1;
    localparam cfg_idx_t REG_Y01 = 3'd2;
    localparam cfg_idx_t REG_Y23 = 3'd3;
    localparam cfg_idx_t REG_Z01 = 3'd4;
    localparam cfg_idx_t REG_Z23 = 3'd5;
    localparam cfg_idx_t REG_W01 = 3'd6;
    localparam cfg_idx_t REG_W23 = 3'd7;

    // Q16.16 constants
    localparam logic [31:0] Q_ONE   = 32'h0001_0000;
    localparam logic [31:0] Q_FOUR  = 32'h0004_0000;
    localparam logic [31:0] Q_32    = 32'h0020_0000;
    localparam logic [31:0] Q_NEG8  = 32'hFFF8_0000;
    localparam logic [31:0] Q_NEG32 = 32'hFFE0_0000;
    localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN   = 32'h8000_0000;
    localparam logic [31:0] Q_M1LSB = 32'hFFFF_FFFF;
    localparam logic [31:0] Q_P1LSB = 32'h0000_0001;

    typedef enum logic [2:0] {
        MAT_RESET,
        MAT_BOX32,
        MAT_OFFSET_MISS,
        MAT_NEG_W,
        MAT_EXTREME
    } dir_mat_e;

    typedef enum int {
        MIX_FRUSTUM,
        MIX_WORDS,
        MIX_CORNERS
    } mix_e;

    typedef struct packed {
        dir_mat_e           mat;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               pinned;
        logic               vis;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_idx_t   cfg_index;
    cfg_word_t  cfg_data;

    cbf_chunk_if chunk_ch ();
    cbf_vis_if   vis_ch ();

    chunk_box_frustum_corner_test_core #(
        .CHUNK_SIZE (CHUNK)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chunk     (chunk_ch),
        .result    (vis_ch)
    );

    cfg_word_t mat_reg  [NUM_REGS];
    cfg_word_t next_mat [NUM_REGS];
    dir_row_t  dir_rows [NUM_DIR];
    logic      vis_expect_q [$];

    // expectation pinned by the directed table, travels with the payload
    logic pin_valid;
    logic pin_vis;

    int send_idle_pct;
    int stall_pct;
    int chunks_taken;
    int results_seen;
    int visible_seen;
    int matrix_loads;
    int errors;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic longint q_val(cfg_word_t w, logic upper);
        return upper ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
    endfunction

    // Any of the eight box corners strictly inside -w < x,y,z < w
    function automatic logic clip_visible(logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] z);
        longint bx, by, bz, cx, cy, cz;
        longint v [4];
        logic   any;
        bx  = longint'(x) * CHUNK_L;
        by  = longint'(y) * CHUNK_L;
        bz  = longint'(z) * CHUNK_L;
        any = 1'b0;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            cx = bx + (k[0] ? CHUNK_L : 64'sd0);
            cy = by + (k[2] ? CHUNK_L : 64'sd0);
            cz = bz + (k[1] ? CHUNK_L : 64'sd0);
            for (int r = 0; r < NUM_ROWS; r++)
                v[r] = q_val(mat_reg[2*r], 1'b0) * cx + q_val(mat_reg[2*r], 1'b1) * cy
                     + q_val(mat_reg[2*r+1], 1'b0) * cz + q_val(mat_reg[2*r+1], 1'b1);
            if (v[0] > -v[3] && v[0] < v[3] && v[1] > -v[3] && v[1] < v[3]
                && v[2] > -v[3] && v[2] < v[3])
                any = 1'b1;
        end
        return any;
    endfunction

    always @(posedge clk)
    begin : watch
        logic want;
        if (rst_n)
        begin
            if (chunk_ch.valid && chunk_ch.ready)
            begin
                vis_expect_q.push_back(pin_valid ? pin_vis :
                    clip_visible(chunk_ch.chunk_x, chunk_ch.chunk_y, chunk_ch.chunk_z));
                chunks_taken++;
            end
            if (vis_ch.valid && vis_ch.ready)
            begin
                results_seen++;
                if (vis_ch.visible)
                    visible_seen++;
                if (vis_expect_q.size() == 0)
                begin
                    errors++;
                    $error("unexpected result transaction: visible expected none, got %0b",
                           vis_ch.visible);
                end
                else
                begin
                    want = vis_expect_q.pop_front();
                    if (want !== vis_ch.visible)
                    begin
                        errors++;
                        $error("visible mismatch: expected %0b, got %0b", want, vis_ch.visible);
                    end
                end
            end
        end
    end

    initial
    begin
        vis_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            vis_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_chunk(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z, input logic pinned,
                              input logic pv);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            chunk_ch.valid <= 1'b0;
            @(negedge clk);
        end
        chunk_ch.valid   <= 1'b1;
        chunk_ch.chunk_x <= x;
        chunk_ch.chunk_y <= y;
        chunk_ch.chunk_z <= z;
        pin_valid        <= pinned;
        pin_vis          <= pv;
        @(posedge clk);
        while (!chunk_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        chunk_ch.valid <= 1'b0;
        while (vis_expect_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH) @(negedge clk);
    endtask

    // Drains the pipe first, so loads happen with the pipe empty
    task automatic load_matrix();
        drain();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we     <= 1'b1;
            cfg_index  <= cfg_idx_t'(i);
            cfg_data   <= next_mat[i];
            mat_reg[i]  = next_mat[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        matrix_loads++;
    endtask

    task automatic set_dir_matrix(input dir_mat_e id);
        foreach (next_mat[i])
            next_mat[i] = '0;
        case (id)
            MAT_BOX32:
            begin
                // x = cx, y = cy, z = cz, w = 32
                next_mat[REG_X01] = {32'h0, Q_ONE};
                next_mat[REG_Y01] = {Q_ONE, 32'h0};
                next_mat[REG_Z23] = {32'h0, Q_ONE};
                next_mat[REG_W23] = {Q_32, 32'h0};
            end
            MAT_OFFSET_MISS:
            begin
                // volume centred on (8,8,8) with half-size 4: chunk 0 straddles it
                next_mat[REG_X01] = {32'h0, Q_ONE};
                next_mat[REG_X23] = {Q_NEG8, 32'h0};
                next_mat[REG_Y01] = {Q_ONE, 32'h0};
                next_mat[REG_Y23] = {Q_NEG8, 32'h0};
                next_mat[REG_Z23] = {Q_NEG8, Q_ONE};
                next_mat[REG_W23] = {Q_FOUR, 32'h0};
            end
            MAT_NEG_W:
            begin
                next_mat[REG_X01] = {32'h0, Q_ONE};
                next_mat[REG_Y01] = {Q_ONE, 32'h0};
                next_mat[REG_Z23] = {32'h0, Q_ONE};
                next_mat[REG_W23] = {Q_NEG32, 32'h0};
            end
            MAT_EXTREME:
            begin
                next_mat[REG_X01] = {Q_MAX, Q_MIN};
                next_mat[REG_X23] = {Q_MIN, Q_MAX};
                next_mat[REG_Y01] = {Q_MIN, Q_MIN};
                next_mat[REG_Y23] = {Q_MAX, Q_MAX};
                next_mat[REG_Z01] = {Q_M1LSB, Q_P1LSB};
                next_mat[REG_Z23] = {32'h0, Q_M1LSB};
                next_mat[REG_W01] = {Q_MAX, Q_MAX};
                next_mat[REG_W23] = {Q_MAX, Q_MAX};
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic entry_t corner_entry();
        case ($urandom_range(0, 3))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic build_random_matrix(input mix_e kind);
        entry_t e [NUM_ROWS][NUM_COLS];
        int     diag;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                case (kind)
                    MIX_FRUSTUM:
                    begin
                        if (r == NUM_ROWS - 1)
                            e[r][c] = (c == NUM_COLS - 1)
                                ? entry_t'($urandom_range(32 << 16, 160 << 16))
                                : entry_t'(int'($urandom_range(0, 8192)) - 4096);
                        else if (c == r)
                        begin
                            // scale of 0.25 .. 2.0, either sign
                            diag = $urandom_range(16384, 131072);
                            e[r][c] = $urandom_range(0, 1) ? entry_t'(-diag) : entry_t'(diag);
                        end
                        else if (c == NUM_COLS - 1)
                            e[r][c] = entry_t'(int'($urandom_range(0, 128 << 16)) - (64 << 16));
                        else
                            e[r][c] = entry_t'(int'($urandom_range(0, 32768)) - 16384);
                    end
                    MIX_WORDS:
                        e[r][c] = entry_t'($urandom);
                    default:
                        e[r][c] = corner_entry();
                endcase
            end
            next_mat[2*r]   = {e[r][1], e[r][0]};
            next_mat[2*r+1] = {e[r][3], e[r][2]};
        end
    endtask

    // mostly a small window round the origin, some full range
    function automatic logic signed [15:0] rand_coord();
        if ($urandom_range(0, 99) < 80)
            return 16'(int'($urandom_range(0, 16)) - 8);
        return 16'($urandom);
    endfunction

    initial
    begin
        dir_mat_e cur_mat;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        chunk_ch.valid   = 1'b0;
        chunk_ch.chunk_x = '0;
        chunk_ch.chunk_y = '0;
        chunk_ch.chunk_z = '0;
        pin_valid        = 1'b0;
        pin_vis          = 1'b0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        chunks_taken     = 0;
        results_seen     = 0;
        visible_seen     = 0;
        matrix_loads     = 0;
        errors           = 0;
        foreach (mat_reg[i])
            mat_reg[i] = '0;

        dir_rows = '{
            // zero matrix after reset: w is zero everywhere
            '{MAT_RESET,        0,      0,      0, 1'b1, 1'b0},
            '{MAT_RESET,    32767,  32767,  32767, 1'b1, 1'b0},
            '{MAT_RESET,   -32768, -32768, -32768, 1'b1, 1'b0},
            '{MAT_RESET,       -1,     -1,     -1, 1'b1, 1'b0},
            // cube of half-size 32 round the origin, corners on the boundary
            '{MAT_BOX32,        0,      0,      0, 1'b0, 1'b0},
            '{MAT_BOX32,        1,      0,      0, 1'b0, 1'b0},
            '{MAT_BOX32,        2,      0,      0, 1'b0, 1'b0},
            '{MAT_BOX32,       -2,      0,      0, 1'b0, 1'b0},
            '{MAT_BOX32,       -3,      0,      0, 1'b0, 1'b0},
            '{MAT_BOX32,        0,      2,      0, 1'b0, 1'b0},
            '{MAT_BOX32,        0,      0,     -3, 1'b0, 1'b0},
            '{MAT_BOX32,    32767,      0,      0, 1'b0, 1'b0},
            '{MAT_BOX32,   -32768, -32768, -32768, 1'b0, 1'b0},
            // straddling box with no corner inside
            '{MAT_OFFSET_MISS,  0,      0,      0, 1'b0, 1'b0},
            '{MAT_OFFSET_MISS, -1,      0,      0, 1'b0, 1'b0},
            '{MAT_OFFSET_MISS,  1,      1,      1, 1'b0, 1'b0},
            // negative w: nothing can be inside
            '{MAT_NEG_W,        0,      0,      0, 1'b1, 1'b0},
            '{MAT_NEG_W,       -1,     -1,     -1, 1'b1, 1'b0},
            '{MAT_EXTREME,  32767, -32768,      0, 1'b0, 1'b0},
            '{MAT_EXTREME, -32768,  32767,     -1, 1'b0, 1'b0},
            '{MAT_EXTREME,      0,      0,      0, 1'b0, 1'b0}
        };

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        cur_mat = MAT_RESET;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].mat != cur_mat)
            begin
                set_dir_matrix(dir_rows[i].mat);
                load_matrix();
                cur_mat = dir_rows[i].mat;
            end
            send_chunk(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                       dir_rows[i].pinned, dir_rows[i].vis);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 62; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            for (int seg = 0; seg < SEGS; seg++)
            begin
                build_random_matrix(seg < 3 ? MIX_FRUSTUM : (seg == 3 ? MIX_WORDS : MIX_CORNERS));
                load_matrix();
                repeat (SEG_ITEMS)
                    send_chunk(rand_coord(), rand_coord(), rand_coord(), 1'b0, 1'b0);
            end
        end

        @(negedge clk);
        chunk_ch.valid <= 1'b0;
        while (vis_expect_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 4) @(negedge clk);

        if (vis_expect_q.size() != 0)
        begin
            errors += vis_expect_q.size();
            $error("%0d visible results never arrived", vis_expect_q.size());
        end

        $display("%0d chunks accepted under %0d matrix loads, four pacing modes",
                 chunks_taken, matrix_loads);
        $display("%0d results checked: %0d visible, %0d culled, %0d mismatches",
                 results_seen, visible_seen, results_seen - visible_seen, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
design/cbf_pkg.sv
design/cbf_chunk_if.sv
design/cbf_vis_if.sv
design/cbf_cfg_regs.sv
design/cbf_row_eval.sv
design/cbf_inside_test.sv
design/chunk_box_frustum_corner_test_core.sv
sim/chunk_box_frustum_corner_test_core_tb.sv
